// ----- src/sorted_key_value_table_top_macros.svh -----
// Assertion macros for the sorted key/value table.
// Define NO_ASSERTIONS to compile them away; users need clk and rst_n in scope.
`ifndef SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define SKVT_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("skvt assertion failed");
// Next-cycle implication, checked out of reset.
`define SKVT_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("skvt assertion failed");
`else
`define SKVT_ASSERT_NOW(lbl, ant, cons)
`define SKVT_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ----- src/skvt_pkg.sv -----
// Shared types and constants for the sorted key/value table.
// No dependencies.
`timescale 1ns / 1ps
package skvt_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;   // address bits for CAPACITY slots
  localparam int CNT_W    = 7;   // count 0..CAPACITY
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_SIZE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic             del;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } skvt_entry_t;

  localparam int ENTRY_W = $bits(skvt_entry_t);
endpackage

// ----- src/skvt_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
module skvt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- src/sorted_key_value_table_top.sv -----
// Sorted key/value table: top level with the operation sequencer.
// Depends on skvt_pkg, skvt_ram and sorted_key_value_table_top_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries op, key and
//    data_value. in_stall is high while an operation is in progress or a
//    result beat still waits on the output, so one operation runs at a time.
//  - Output channel (out_valid / out_stall): exactly one result beat per
//    input beat, in order. The result register holds while out_stall is high.
//  - Slots are reached through the single read port and single write port
//    of the RAM. Each binary-search probe passes an address state and a
//    compare state, up to 7 probes over 64 slots. Insert adds a slot check
//    and, on a miss, a shift of the later slots. A full table with deleted
//    slots is compacted first and searched again. Size compacts when there
//    is garbage. Clear, size without garbage and unknown ops go straight to
//    the done state.
//  - The worst case is a full compaction, a re-search and a shift; the shift
//    and compaction sweeps over the RAM port set it. The next beat can be
//    accepted in the cycle after the result beat is taken.
//  - Reset clears the used count, the garbage flag and the handshake state;
//    slot contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
`include "sorted_key_value_table_top_macros.svh"
module sorted_key_value_table_top
  import skvt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0]        in_data_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [VAL_W-1:0]        out_read_value,
  output logic [CNT_W-1:0]        out_entry_total,
  output logic                    out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_CMP, S_DECIDE, S_CHK, S_SHIFT, S_COMPACT, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Operation beat, held for the whole operation.
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  // Table bookkeeping.
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             garb_r, garb_nxt;

  // Binary search.
  logic signed [CNT_W:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]      mid_r, mid_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  hit_r, hit_nxt;
  skvt_entry_t           ent_r, ent_nxt;

  // Shift and compaction sweeps.
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             pend_r, pend_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             status_r, status_nxt;

  // RAM port.
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  skvt_entry_t      wdata, rdata;

  logic [CNT_W:0]   lh_sum;
  logic [CNT_W-1:0] pos_m1;

  skvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall        = (state_r != S_IDLE) || out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_read_value  = rv_r;
  assign out_entry_total = total_r;
  assign out_status      = status_r;

  assign lh_sum = lo_r + hi_r;
  assign pos_m1 = j_r - 7'd1;

  always_comb begin
    logic place;
    place         = 1'b0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    used_nxt      = used_r;
    garb_nxt      = garb_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    ent_nxt       = ent_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    rv_nxt        = rv_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    we            = 1'b0;
    waddr         = pos_r[IDX_W-1:0];
    wdata         = '{del: 1'b0, key: key_r, val: val_r};
    re            = 1'b0;
    raddr         = pos_r[IDX_W-1:0];

    // Drop the result once it is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt     = in_op;
          key_nxt    = in_key;
          val_nxt    = in_data_value;
          found_nxt  = 1'b0;
          rv_nxt     = '0;
          status_nxt = 1'b0;
          hit_nxt    = 1'b0;
          lo_nxt     = '0;
          hi_nxt     = $signed({1'b0, used_r}) - 8'sd1;
          case (in_op)
            OP_INSERT, OP_REMOVE, OP_FIND: state_nxt = S_SRCH;
            OP_SIZE: begin
              if (garb_r) begin
                j_nxt     = '0;
                w_nxt     = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_COMPACT;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_CLEAR: begin
              used_nxt  = '0;
              garb_nxt  = 1'b0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r <= hi_r) begin
          re        = 1'b1;
          raddr     = lh_sum[IDX_W:1];
          mid_nxt   = lh_sum[IDX_W:1];
          state_nxt = S_CMP;
        end else begin
          pos_nxt   = lo_r[CNT_W-1:0];
          hit_nxt   = 1'b0;
          state_nxt = S_DECIDE;
        end
      end
      S_CMP: begin
        if ($signed(rdata.key) < $signed(key_r)) begin
          lo_nxt    = $signed({2'b00, mid_r}) + 8'sd1;
          state_nxt = S_SRCH;
        end else if ($signed(rdata.key) > $signed(key_r)) begin
          hi_nxt    = $signed({2'b00, mid_r}) - 8'sd1;
          state_nxt = S_SRCH;
        end else begin
          hit_nxt   = 1'b1;
          pos_nxt   = {1'b0, mid_r};
          ent_nxt   = rdata;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (hit_r) begin
              we = 1'b1;  // overwrite value, revive if deleted
            end else if (pos_r < used_r) begin
              re        = 1'b1;
              state_nxt = S_CHK;
            end else begin
              place = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hit_r && !ent_r.del) begin
              we       = 1'b1;
              wdata    = '{del: 1'b1, key: ent_r.key, val: ent_r.val};
              garb_nxt = 1'b1;
            end
          end
          OP_FIND: begin
            if (hit_r && !ent_r.del) begin
              found_nxt = 1'b1;
              rv_nxt    = ent_r.val;
            end
          end
          default: ;
        endcase
      end
      S_CHK: begin
        if (rdata.del) begin
          we        = 1'b1;  // reuse the deleted slot at the insertion point
          state_nxt = S_DONE;
        end else begin
          place = 1'b1;
        end
      end
      S_SHIFT: begin
        // Move slot j-1 up to j, top down; write the new entry last.
        if (pend_r) begin
          we    = 1'b1;
          waddr = w_r[IDX_W-1:0];
          wdata = rdata;
        end
        if (j_r > pos_r) begin
          re       = 1'b1;
          raddr    = pos_m1[IDX_W-1:0];
          pend_nxt = 1'b1;
          w_nxt    = j_r;
          j_nxt    = pos_m1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            we        = 1'b1;
            used_nxt  = used_r + 7'd1;
            state_nxt = S_DONE;
          end
        end
      end
      S_COMPACT: begin
        // Read slot j, next cycle keep it at w if live.
        if (pend_r && !rdata.del) begin
          we    = 1'b1;
          waddr = w_r[IDX_W-1:0];
          wdata = rdata;
          w_nxt = w_r + 7'd1;
        end
        if (j_r < used_r) begin
          re       = 1'b1;
          raddr    = j_r[IDX_W-1:0];
          pend_nxt = 1'b1;
          j_nxt    = j_r + 7'd1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            used_nxt = w_r;
            garb_nxt = 1'b0;
            if (op_r == OP_INSERT) begin
              lo_nxt    = '0;
              hi_nxt    = $signed({1'b0, w_r}) - 8'sd1;
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        total_nxt     = used_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Insert miss with no reusable slot: compact, shift in, or reject.
    if (place) begin
      if (garb_r && (used_r >= 7'(CAPACITY))) begin
        j_nxt     = '0;
        w_nxt     = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_COMPACT;
      end else if (used_r < 7'(CAPACITY)) begin
        j_nxt     = used_r;
        pend_nxt  = 1'b0;
        state_nxt = S_SHIFT;
      end else begin
        status_nxt = 1'b1;
        state_nxt  = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      garb_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      garb_r      <= garb_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    ent_r    <= ent_nxt;
    j_r      <= j_nxt;
    w_r      <= w_nxt;
    found_r  <= found_nxt;
    rv_r     <= rv_nxt;
    total_r  <= total_nxt;
    status_r <= status_nxt;
  end

  `SKVT_ASSERT_NOW(a_used_bound, 1'b1, used_r <= 7'(CAPACITY))
  `SKVT_ASSERT_NOW(a_result_idle, out_valid_r, state_r == S_IDLE)
  `SKVT_ASSERT_NOW(a_port_clash, we && re, waddr != raddr)
  `SKVT_ASSERT_NOW(a_status_insert, out_valid_r && status_r, op_r == OP_INSERT)
  `SKVT_ASSERT_NEXT(a_clear_empties, state_r == S_IDLE && in_valid && !in_stall &&
                    in_op == OP_CLEAR, used_r == 7'd0 && !garb_r)

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for sorted_key_value_table_top: directed table, fill to capacity, then random traffic.
// Depends on skvt_pkg and the sorted_key_value_table_top RTL; self-checking predictor.
`timescale 1ns / 1ps
module tb;
  import skvt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_data_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [VAL_W-1:0] out_read_value;
  logic [CNT_W-1:0] out_entry_total;
  logic out_status;

  sorted_key_value_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_key(in_key), .in_data_value(in_data_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_read_value(out_read_value),
    .out_entry_total(out_entry_total), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] total;
    logic             status;
  } table_reply_t;

  // One directed row: the beat, plus an optional typed-in answer.
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               fixed;
    table_reply_t     reply;
  } stim_row_t;

  // Shadow copy of the table.
  logic [KEY_W-1:0] shadow_key [CAPACITY];
  logic [VAL_W-1:0] shadow_val [CAPACITY];
  logic             shadow_del [CAPACITY];
  int unsigned      shadow_used;
  bit               shadow_garbage;

  table_reply_t pending_replies[$];
  int  mismatches;
  int  sent_beats;
  bit  hold_off_now;

  // Binary search over used slots; returns hit and slot or insertion point.
  function automatic bit search_slot(input logic [KEY_W-1:0] k, output int pos);
    int lo, hi, mid;
    lo = 0;
    hi = int'(shadow_used) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >>> 1;
      if ($signed(shadow_key[mid]) < $signed(k)) lo = mid + 1;
      else if ($signed(shadow_key[mid]) > $signed(k)) hi = mid - 1;
      else begin
        pos = mid;
        return 1'b1;
      end
    end
    pos = lo;
    return 1'b0;
  endfunction

  function automatic void squeeze_deleted();
    int w;
    w = 0;
    for (int i = 0; i < int'(shadow_used); i++) begin
      if (!shadow_del[i]) begin
        shadow_key[w] = shadow_key[i];
        shadow_val[w] = shadow_val[i];
        shadow_del[w] = 1'b0;
        w++;
      end
    end
    shadow_used = w;
    shadow_garbage = 1'b0;
  endfunction

  // Apply one beat to the shadow table and return the expected reply.
  function automatic table_reply_t table_apply(input logic [OP_W-1:0] op,
      input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    table_reply_t r;
    int pos;
    bit hit;
    r = '0;
    case (op)
      OP_INSERT: begin
        hit = search_slot(k, pos);
        if (hit) begin
          shadow_val[pos] = v;
          shadow_del[pos] = 1'b0;
        end else if (pos < int'(shadow_used) && shadow_del[pos]) begin
          shadow_key[pos] = k;
          shadow_val[pos] = v;
          shadow_del[pos] = 1'b0;
        end else begin
          if (shadow_garbage && shadow_used >= CAPACITY) begin
            squeeze_deleted();
            void'(search_slot(k, pos));
          end
          if (shadow_used < CAPACITY) begin
            for (int i = int'(shadow_used); i > pos; i--) begin
              shadow_key[i] = shadow_key[i-1];
              shadow_val[i] = shadow_val[i-1];
              shadow_del[i] = shadow_del[i-1];
            end
            shadow_key[pos] = k;
            shadow_val[pos] = v;
            shadow_del[pos] = 1'b0;
            shadow_used++;
          end else begin
            r.status = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (search_slot(k, pos) && !shadow_del[pos]) begin
          shadow_del[pos] = 1'b1;
          shadow_garbage = 1'b1;
        end
      end
      OP_FIND: begin
        if (search_slot(k, pos) && !shadow_del[pos]) begin
          r.found = 1'b1;
          r.value = shadow_val[pos];
        end
      end
      OP_SIZE: if (shadow_garbage) squeeze_deleted();
      OP_CLEAR: begin
        shadow_used = 0;
        shadow_garbage = 1'b0;
      end
      default: ;
    endcase
    r.total = shadow_used[CNT_W-1:0];
    return r;
  endfunction

  // Offer one beat at the falling edge; hold it until accepted.
  task automatic offer_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
      input logic [VAL_W-1:0] v, input bit fixed, input table_reply_t fixed_reply);
    table_reply_t r;
    in_op = op;
    in_key = k;
    in_data_value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = table_apply(op, k, v);
    if (fixed && r != fixed_reply) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row %0d: table answer %h, typed-in %h", sent_beats, r, fixed_reply);
    end
    pending_replies.push_back(r);
    sent_beats++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Pick a key: mostly from a small pool so hits, deletes and revivals are common.
  function automatic logic [KEY_W-1:0] pick_key(input int span);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom;
      default: return $urandom_range(0, span) - span / 2;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int fill_bias);
    int p;
    p = $urandom_range(0, 99);
    if (p < fill_bias) return OP_INSERT;
    if (p < fill_bias + 15) return OP_REMOVE;
    if (p < fill_bias + 35) return OP_FIND;
    if (p < 94) return OP_SIZE;
    if (p < 97) return OP_CLEAR;
    return OP_W'($urandom_range(5, 7));
  endfunction

  // Receiver: stall on its own pattern, with long hold-offs started while 400 < sent_beats < 420.
  initial begin
    int mode;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_now) out_stall = 1'b1;
      else begin
        mode = (sent_beats / 150) % 3;
        if (mode == 0) out_stall = 1'b0;
        else if (mode == 1) out_stall = ($urandom_range(0, 3) == 0);
        else out_stall = ($urandom_range(0, 1) == 0);
      end
    end
  end

  // Check result beats against the oldest expectation.
  always @(posedge clk) begin
    table_reply_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_found, out_read_value, out_entry_total, out_status};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp f=%b v=%h n=%0d s=%b, got f=%b v=%h n=%0d s=%b",
                     want.found, want.value, want.total, want.status,
                     got.found, got.value, got.total, got.status);
        end
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
      input logic [VAL_W-1:0] v, input bit fixed, input table_reply_t rep);
    stim_row_t s;
    s.op = op; s.key = k; s.val = v; s.fixed = fixed; s.reply = rep;
    return s;
  endfunction

  initial begin
    int burst, bias, wait_cycles;
    logic [OP_W-1:0] op;
    mismatches = 0;
    sent_beats = 0;
    hold_off_now = 1'b0;
    shadow_used = 0;
    shadow_garbage = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_key[i] = '0; shadow_val[i] = '0; shadow_del[i] = 1'b0;
    end

    // Directed rows: empty-table answers, key extremes, deletes, revival.
    directed.push_back(row(OP_FIND,   32'h0,         32'h0,         1, '{0, 0, 0, 0}));
    directed.push_back(row(OP_SIZE,   32'h0,         32'h0,         1, '{0, 0, 0, 0}));
    directed.push_back(row(3'd5,      32'h1,         32'h1,         1, '{0, 0, 0, 0}));
    directed.push_back(row(OP_REMOVE, 32'h5,         32'h0,         1, '{0, 0, 0, 0}));
    directed.push_back(row(OP_INSERT, 32'h8000_0000, 32'hffff_ffff, 1, '{0, 0, 1, 0}));
    directed.push_back(row(OP_INSERT, 32'h7fff_ffff, 32'h0,         1, '{0, 0, 2, 0}));
    directed.push_back(row(OP_INSERT, 32'hffff_ffff, 32'haaaa_5555, 1, '{0, 0, 3, 0}));
    directed.push_back(row(OP_INSERT, 32'h0,         32'h5555_aaaa, 1, '{0, 0, 4, 0}));
    directed.push_back(row(OP_FIND,   32'h8000_0000, 32'h0,         1, '{1, 32'hffff_ffff, 4, 0}));
    directed.push_back(row(OP_FIND,   32'h7fff_ffff, 32'h0,         1, '{1, 0, 4, 0}));
    directed.push_back(row(OP_INSERT, 32'h0,         32'h1234_5678, 0, '0));
    directed.push_back(row(OP_REMOVE, 32'hffff_ffff, 32'h0,         0, '0));
    directed.push_back(row(OP_REMOVE, 32'hffff_ffff, 32'h0,         0, '0));
    directed.push_back(row(OP_FIND,   32'hffff_ffff, 32'h0,         1, '{0, 0, 4, 0}));
    directed.push_back(row(OP_INSERT, 32'hffff_fffe, 32'h0bad_f00d, 0, '0));
    directed.push_back(row(OP_REMOVE, 32'h0,         32'h0,         0, '0));
    directed.push_back(row(OP_INSERT, 32'h0,         32'hcafe_0001, 0, '0));
    directed.push_back(row(OP_REMOVE, 32'h7fff_ffff, 32'h0,         0, '0));
    directed.push_back(row(OP_SIZE,   32'h0,         32'h0,         1, '{0, 0, 3, 0}));
    directed.push_back(row(3'd7,      32'hffff_ffff, 32'hffff_ffff, 1, '{0, 0, 3, 0}));
    directed.push_back(row(3'd6,      32'h0,         32'h0,         0, '0));
    directed.push_back(row(OP_CLEAR,  32'h0,         32'h0,         1, '{0, 0, 0, 0}));
    directed.push_back(row(OP_FIND,   32'h0,         32'h0,         1, '{0, 0, 0, 0}));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      offer_beat(directed[i].op, directed[i].key, directed[i].val,
                 directed[i].fixed, directed[i].reply);

    // Fill to capacity, hit the full-table reject, then compact through a full insert.
    for (int i = 0; i < CAPACITY + 2; i++)
      offer_beat(OP_INSERT, 32'(i * 3 - 90), $urandom, 0, '0);
    offer_beat(OP_REMOVE, 32'(-90 + 30), 0, 0, '0);
    offer_beat(OP_REMOVE, 32'(-90 + 60), 0, 0, '0);
    offer_beat(OP_INSERT, 32'(-90 + 31), $urandom, 0, '0);
    offer_beat(OP_INSERT, 32'h8000_0000, $urandom, 0, '0);
    offer_beat(OP_INSERT, 32'h7fff_ffff, $urandom, 0, '0);

    // Random part in bursts; some phases bias toward filling the table.
    while (sent_beats < 1050) begin
      if (sent_beats > 400 && sent_beats < 420 && !hold_off_now) begin
        // Hold the receiver off while the sender keeps offering.
        fork
          begin
            hold_off_now = 1'b1;
            repeat (300) @(negedge clk);
            hold_off_now = 1'b0;
          end
        join_none
      end
      bias = ((sent_beats / 100) % 2) ? 60 : 35;
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        op = pick_op(bias);
        offer_beat(op, pick_key((sent_beats / 200) % 2 ? 40 : 160), $urandom, 0, '0);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 12));
    end
    in_valid = 1'b0;

    wait_cycles = 0;
    while (pending_replies.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
